// ----- design/slxfp_pkg.sv -----
// Package for the sync/length/XOR frame parser.
// Holds the parse state type, the protocol byte constants and the structs
// shared by the step logic and the top level. Depends on nothing.
`default_nettype none

package slxfp_pkg;

  // Sync sequence, delimiter and the XOR of the fixed header bytes
  localparam logic [7:0] SYNC_0    = 8'h55;
  localparam logic [7:0] SYNC_1    = 8'h4E;
  localparam logic [7:0] SYNC_2    = 8'h45;
  localparam logic [7:0] SYNC_3    = 8'h52;
  localparam logic [7:0] DELIM     = 8'h3A;
  localparam logic [7:0] HDR_CHECK = SYNC_0 ^ SYNC_1 ^ SYNC_2 ^ SYNC_3 ^ DELIM;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_N     = 3'd1,
    ST_E     = 3'd2,
    ST_R     = 3'd3,
    ST_COUNT = 3'd4,
    ST_DELIM = 3'd5,
    ST_PAY   = 3'd6
  } parse_state_t;

  // Parser context carried from one byte to the next
  typedef struct packed {
    parse_state_t state;
    logic [7:0]   bytes_left;
    logic [7:0]   running_check;
  } slxfp_ctx_t;

  // Classification of one byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       frame_end;
    logic       frame_good;
  } slxfp_result_t;

endpackage : slxfp_pkg

`default_nettype wire

// ----- design/slxfp_if.sv -----
// Valid/ready channel interfaces of the frame parser: received bytes in,
// classified bytes out. Depends on nothing.
`default_nettype none

interface slxfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : slxfp_in_if

interface slxfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       payload_valid;
  logic       frame_end;
  logic       frame_good;

  modport source (output valid, output out_byte, output payload_valid,
                  output frame_end, output frame_good, input ready);
  modport sink   (input valid, input out_byte, input payload_valid,
                  input frame_end, input frame_good, output ready);
endinterface : slxfp_out_if

`default_nettype wire

// ----- design/slxfp_step.sv -----
// Per-byte step logic of the frame parser: next context and classification
// of one received byte. Depends on slxfp_pkg.
`default_nettype none

module slxfp_step (
  input  slxfp_pkg::slxfp_ctx_t    ctx_cur,
  input  logic [7:0]               rx_byte,
  output slxfp_pkg::slxfp_ctx_t    ctx_nxt,
  output slxfp_pkg::slxfp_result_t result
);

  logic [7:0]                left_dec;
  slxfp_pkg::parse_state_t   hunt_state;

  assign left_dec   = ctx_cur.bytes_left - 8'd1;
  // A byte that breaks the header is retried as a possible first sync byte
  assign hunt_state = (rx_byte == slxfp_pkg::SYNC_0) ? slxfp_pkg::ST_N : slxfp_pkg::ST_HUNT;

  // Advance the parser by one byte
  always_comb begin
    ctx_nxt              = ctx_cur;
    result.out_byte      = rx_byte;
    result.payload_valid = 1'b0;
    result.frame_end     = 1'b0;
    result.frame_good    = 1'b0;
    case (ctx_cur.state)
      slxfp_pkg::ST_HUNT: begin
        ctx_nxt.state = hunt_state;
      end
      slxfp_pkg::ST_N: begin
        if (rx_byte == slxfp_pkg::SYNC_1) begin
          ctx_nxt.state = slxfp_pkg::ST_E;
        end else if (rx_byte != slxfp_pkg::SYNC_0) begin
          ctx_nxt.state = slxfp_pkg::ST_HUNT;
        end
      end
      slxfp_pkg::ST_E: begin
        ctx_nxt.state = (rx_byte == slxfp_pkg::SYNC_2) ? slxfp_pkg::ST_R : hunt_state;
      end
      slxfp_pkg::ST_R: begin
        ctx_nxt.state = (rx_byte == slxfp_pkg::SYNC_3) ? slxfp_pkg::ST_COUNT : hunt_state;
      end
      slxfp_pkg::ST_COUNT: begin
        ctx_nxt.bytes_left = rx_byte;
        ctx_nxt.state      = slxfp_pkg::ST_DELIM;
      end
      slxfp_pkg::ST_DELIM: begin
        if (rx_byte == slxfp_pkg::DELIM) begin
          ctx_nxt.state         = slxfp_pkg::ST_PAY;
          ctx_nxt.running_check = slxfp_pkg::HDR_CHECK ^ ctx_cur.bytes_left;
        end else begin
          ctx_nxt.state = hunt_state;
        end
      end
      slxfp_pkg::ST_PAY: begin
        ctx_nxt.bytes_left = left_dec;
        if (left_dec != 8'd0) begin
          ctx_nxt.running_check = ctx_cur.running_check ^ rx_byte;
          result.payload_valid  = 1'b1;
        end else begin
          // Checksum byte closes the frame and is not retried as a sync start
          ctx_nxt.state     = slxfp_pkg::ST_HUNT;
          result.frame_end  = 1'b1;
          result.frame_good = (rx_byte == ctx_cur.running_check);
        end
      end
      default: begin
        ctx_nxt.state = slxfp_pkg::ST_HUNT;
      end
    endcase
  end

endmodule : slxfp_step

`default_nettype wire

// ----- design/sync_length_xor_frame_parser.sv -----
// Sync/length/XOR-checksum frame parser, top level.
// Depends on slxfp_pkg, slxfp_if (slxfp_in_if, slxfp_out_if) and slxfp_step.
//
// Usage:
//   in_chan  carries one received byte per transfer (rx_byte).
//   out_chan returns one result per input byte: the byte echoed, a payload
//            flag, a frame-end flag on the closing checksum byte and, with it,
//            a checksum-match flag.
//   Each byte's result is registered and offered on out_chan from the cycle
//   after the byte is taken. Throughput is one byte per cycle while the
//   receiver keeps up, set by the single result register; the parser context
//   updates in the same cycle that a byte is taken.
//   When the receiver stalls, the result register holds its value and
//   in_chan.ready stays high only while the register is being emptied in the
//   same cycle, so a new byte is taken exactly when its result has a place.
//   Reset (rst_n low, synchronous) puts the parser into the hunt for the
//   first sync byte, clears the byte count and checksum, and empties the
//   result register. No clearing pass follows; bytes are taken at once.
`default_nettype none

module sync_length_xor_frame_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  slxfp_in_if.sink        in_chan,
  slxfp_out_if.source     out_chan
);

  slxfp_pkg::slxfp_ctx_t    ctx_r;
  slxfp_pkg::slxfp_ctx_t    ctx_nxt;
  slxfp_pkg::slxfp_result_t res_r;
  slxfp_pkg::slxfp_result_t res_nxt;
  logic                     out_valid_r;
  logic                     in_fire;
  logic                     out_fire;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_valid_r && out_chan.ready;

  slxfp_step u_step (
    .ctx_cur (ctx_r),
    .rx_byte (in_chan.rx_byte),
    .ctx_nxt (ctx_nxt),
    .result  (res_nxt)
  );

  // Advance the parser context on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state         <= slxfp_pkg::ST_HUNT;
      ctx_r.bytes_left    <= 8'd0;
      ctx_r.running_check <= 8'd0;
    end else if (in_fire) begin
      ctx_r <= ctx_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = res_r.out_byte;
  assign out_chan.payload_valid = res_r.payload_valid;
  assign out_chan.frame_end     = res_r.frame_end;
  assign out_chan.frame_good    = res_r.frame_good;

  // A byte taken as the last of a frame sends the parser back to the hunt
  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ctx_r.state == slxfp_pkg::ST_PAY && ctx_r.bytes_left == 8'd1)
    |=> (ctx_r.state == slxfp_pkg::ST_HUNT && out_chan.frame_end))
    else $error("frame end did not return parser to hunt");

  // A byte is never both payload and frame end, and a good frame is an end
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!(res_r.payload_valid && res_r.frame_end)
                     && (!res_r.frame_good || res_r.frame_end)))
    else $error("inconsistent result flags");

  // Every input transfer leaves a result waiting at the next edge
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("result lost after input transfer");

  // Payload flag only while the parser was in the payload phase
  a_pay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ctx_r.state != slxfp_pkg::ST_PAY |=> !res_r.payload_valid && !res_r.frame_end)
    else $error("payload flag outside payload phase");

endmodule : sync_length_xor_frame_parser

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for sync_length_xor_frame_parser: streams directed and random byte
// sequences and checks every classified byte against an in-bench parser model.
// Depends on slxfp_pkg, slxfp_in_if, slxfp_out_if and the parser top level.
`timescale 1ns / 100ps

module testbench;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_BYTES = 1700;

  logic clk = 1'b0;
  logic rst_n;

  slxfp_in_if  in_ch ();
  slxfp_out_if out_ch ();

  sync_length_xor_frame_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Bytes waiting to be sent and classifications waiting to come back
  logic [7:0]               tx_bytes [$];
  slxfp_pkg::slxfp_result_t class_q [$];

  int failures     = 0;
  int total_bytes  = 0;
  int bytes_taken  = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // Parser model state
  slxfp_pkg::parse_state_t pstate;
  logic [7:0]              left_cnt;
  logic [7:0]              xor_acc;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A 'U' in the hunt starts a sync sequence
  function automatic slxfp_pkg::parse_state_t hunt_from(input logic [7:0] b);
    return (b == slxfp_pkg::SYNC_0) ? slxfp_pkg::ST_N : slxfp_pkg::ST_HUNT;
  endfunction

  // Advance the parser model by one byte and return its classification
  function automatic slxfp_pkg::slxfp_result_t classify_byte(input logic [7:0] b);
    slxfp_pkg::slxfp_result_t r;
    r = '0;
    r.out_byte = b;
    case (pstate)
      slxfp_pkg::ST_HUNT: pstate = hunt_from(b);
      slxfp_pkg::ST_N: begin
        if (b == slxfp_pkg::SYNC_1) pstate = slxfp_pkg::ST_E;
        else if (b != slxfp_pkg::SYNC_0) pstate = slxfp_pkg::ST_HUNT;
      end
      slxfp_pkg::ST_E:
        pstate = (b == slxfp_pkg::SYNC_2) ? slxfp_pkg::ST_R : hunt_from(b);
      slxfp_pkg::ST_R:
        pstate = (b == slxfp_pkg::SYNC_3) ? slxfp_pkg::ST_COUNT : hunt_from(b);
      slxfp_pkg::ST_COUNT: begin
        left_cnt = b;
        pstate   = slxfp_pkg::ST_DELIM;
      end
      slxfp_pkg::ST_DELIM: begin
        if (b == slxfp_pkg::DELIM) begin
          pstate  = slxfp_pkg::ST_PAY;
          xor_acc = slxfp_pkg::HDR_CHECK ^ left_cnt;
        end else begin
          pstate = hunt_from(b);
        end
      end
      slxfp_pkg::ST_PAY: begin
        left_cnt = left_cnt - 8'd1;
        if (left_cnt != 8'd0) begin
          xor_acc         = xor_acc ^ b;
          r.payload_valid = 1'b1;
        end else begin
          pstate       = slxfp_pkg::ST_HUNT;
          r.frame_end  = 1'b1;
          r.frame_good = (b == xor_acc);
        end
      end
      default: pstate = slxfp_pkg::ST_HUNT;
    endcase
    return r;
  endfunction

  // Idle share in percent for the current third of the run
  function automatic int idle_pct(input int done, input bit is_sender);
    if (done * 3 < total_bytes) return is_sender ? 30 : 57;
    if (done * 3 < total_bytes * 2) return is_sender ? 57 : 30;
    return 0;
  endfunction

  // Random byte, biased toward the protocol bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return slxfp_pkg::SYNC_0;
      1: return ($urandom_range(1) != 0) ? slxfp_pkg::SYNC_1 : slxfp_pkg::SYNC_2;
      2: return ($urandom_range(1) != 0) ? slxfp_pkg::SYNC_3 : slxfp_pkg::DELIM;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_seq(input logic [7:0] seq []);
    foreach (seq[i]) tx_bytes.push_back(seq[i]);
  endtask

  // Queue one whole frame with random payload and a good or corrupted checksum
  task automatic push_frame(input logic [7:0] count, input bit good);
    logic [7:0] chk;
    logic [7:0] b;
    int         n;
    chk = slxfp_pkg::HDR_CHECK ^ count;
    push_seq('{slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2,
               slxfp_pkg::SYNC_3, count, slxfp_pkg::DELIM});
    n = (count == 8'd0) ? 255 : int'(count) - 1;
    for (int i = 0; i < n; i++) begin
      b   = pick_byte();
      chk = chk ^ b;
      tx_bytes.push_back(b);
    end
    if (good) tx_bytes.push_back(chk);
    else tx_bytes.push_back(chk ^ 8'($urandom_range(1, 255)));
  endtask

  // Queue a header cut short at a random point (a lone 'U' may be followed by more 'U' bytes), then a random byte
  task automatic push_broken();
    logic [7:0] hdr [6];
    int         k;
    hdr = '{slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2, slxfp_pkg::SYNC_3,
            8'($urandom_range(1, 10)), slxfp_pkg::DELIM};
    k = $urandom_range(1, 5);
    for (int i = 0; i < k; i++) tx_bytes.push_back(hdr[i]);
    if (k == 1) begin
      repeat ($urandom_range(0, 3)) tx_bytes.push_back(slxfp_pkg::SYNC_0);
    end
    tx_bytes.push_back(pick_byte());
  endtask

  // Stimulus, reset and end of run
  initial begin
    int r;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    pstate        = slxfp_pkg::ST_HUNT;
    left_cnt      = 8'h00;
    xor_acc       = 8'h00;

    // Byte extremes while hunting
    push_seq('{8'h00, 8'hFF});
    // Repeated sync start, count of one: first byte after the delimiter closes
    push_seq('{slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2,
               slxfp_pkg::SYNC_3, 8'h01, slxfp_pkg::DELIM, slxfp_pkg::HDR_CHECK ^ 8'h01});
    // 'U' where 'R' is due restarts the sync; 'U' where ':' is due does too
    push_seq('{slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2, slxfp_pkg::SYNC_0,
               slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2, slxfp_pkg::SYNC_3, 8'h02,
               slxfp_pkg::SYNC_0});
    push_seq('{slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2, slxfp_pkg::SYNC_3, 8'h02,
               slxfp_pkg::DELIM, 8'hFF, slxfp_pkg::HDR_CHECK ^ 8'h02 ^ 8'hFF});
    // Bad checksum that is itself a 'U' must not restart the sync; then 'E' mismatch
    push_seq('{slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1, slxfp_pkg::SYNC_2, slxfp_pkg::SYNC_3,
               8'h01, slxfp_pkg::DELIM, slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1});
    push_seq('{slxfp_pkg::SYNC_0, slxfp_pkg::SYNC_1, 8'h00});

    // Largest counts, then random traffic
    push_frame(8'h00, 1'b1);
    push_frame(8'hFF, 1'b0);
    while (tx_bytes.size() < RANDOM_BYTES) begin
      r = $urandom_range(99);
      if (r < 65) begin
        if ($urandom_range(99) == 0) push_frame(8'($urandom_range(255)), 1'($urandom_range(1)));
        else push_frame(8'($urandom_range(1, 10)), $urandom_range(99) < 75);
      end else if (r < 85) begin
        push_broken();
      end else begin
        repeat ($urandom_range(1, 6)) tx_bytes.push_back(pick_byte());
      end
    end
    total_bytes = tx_bytes.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen < total_bytes) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && class_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver: record accepted bytes, hold the current byte, offer the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        class_q.push_back(classify_byte(in_ch.rx_byte));
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= idle_pct(bytes_taken, 1'b1)) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= tx_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      failures++;
    end
  endtask

  // Monitor: check each result transfer against the oldest classification
  always @(posedge clk) begin
    slxfp_pkg::slxfp_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (class_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %0h", $time,
                   out_ch.out_byte);
          failures++;
        end else begin
          want = class_q.pop_front();
          compare_field("out_byte", want.out_byte, out_ch.out_byte);
          compare_field("payload_valid", 8'(want.payload_valid), 8'(out_ch.payload_valid));
          compare_field("frame_end", 8'(want.frame_end), 8'(out_ch.frame_end));
          compare_field("frame_good", 8'(want.frame_good), 8'(out_ch.frame_good));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct(results_seen, 1'b0));
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule : testbench
